[design/cfr_pkg.sv]
// Shared types and constants for the command frame receiver.
// No dependencies; each design file but cfr_checker uses its scoped names.
package cfr_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MARKER = 2'd0;
  localparam logic [1:0] CFG_OWN_BOARD_ID = 2'd1;
  localparam logic [1:0] CFG_FRAME_TIMEOUT = 2'd2;

  // Register reset values
  localparam logic [7:0]  START_MARKER_RST = 8'd170;
  localparam logic [7:0]  OWN_BOARD_ID_RST = 8'd1;
  localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd100;

  // Frame geometry: bytes after the marker, and index of the checksum byte
  localparam int unsigned BODY_LEN = 5;
  localparam logic [2:0]  LAST_IDX = 3'd4;

  // One received byte with its timestamp
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
  } cfr_item_t;

  // One decoded frame
  typedef struct packed {
    logic [7:0] node_id;
    logic [7:0] device_addr;
    logic [7:0] command;
    logic [7:0] parameter_res;
    logic [7:0] checksum;
  } cfr_frame_t;

  // Register file contents seen by the frame logic
  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  own_node_id;
    logic [15:0] frame_timeout_ms;
  } cfr_cfg_t;

endpackage

[design/cfr_cfg_regs.sv]
// Configuration register file of the command frame receiver.
// Depends on cfr_pkg for register indexes, reset values and cfr_cfg_t.
module cfr_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  output cfr_pkg::cfr_cfg_t cfg
);

  logic [7:0]  start_marker_r;
  logic [7:0]  own_node_id_r;
  logic [15:0] frame_timeout_r;

  // Write one register per transaction; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r  <= cfr_pkg::START_MARKER_RST;
      own_node_id_r   <= cfr_pkg::OWN_BOARD_ID_RST;
      frame_timeout_r <= cfr_pkg::FRAME_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cfr_pkg::CFG_START_MARKER:  start_marker_r  <= cfg_wdata[7:0];
        cfr_pkg::CFG_OWN_BOARD_ID:  own_node_id_r   <= cfg_wdata[7:0];
        cfr_pkg::CFG_FRAME_TIMEOUT: frame_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.start_marker     = start_marker_r;
  assign cfg.own_node_id      = own_node_id_r;
  assign cfg.frame_timeout_ms = frame_timeout_r;

endmodule

[design/cfr_in_stage.sv]
// Input register of the command frame receiver: holds one received byte.
// Depends on cfr_pkg for cfr_item_t.
module cfr_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic [31:0]        in_now_ms,
  input  logic               advance,
  output logic               item_valid,
  output cfr_pkg::cfr_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  cfr_pkg::cfr_item_t item_r;
  logic               load;

  // Stall only while a held item cannot move on
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the transaction payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.rx_byte <= in_rx_byte;
      item_r.now_ms  <= in_now_ms;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[design/cfr_frame_core.sv]
// Frame tracking of the command frame receiver: marker search, timeout,
// byte collection and the checksum and board id test. Depends on cfr_pkg.
module cfr_frame_core (
  input  logic                clk,
  input  logic                rst_n,
  input  cfr_pkg::cfr_cfg_t   cfg,
  input  logic                step,
  input  cfr_pkg::cfr_item_t  item,
  output logic                res_valid,
  output cfr_pkg::cfr_frame_t res
);

  localparam int unsigned STORE_N = cfr_pkg::BODY_LEN - 1;

  logic             collecting_r;
  logic             collecting_nxt;
  logic [2:0]       byte_count_r;
  logic [2:0]       byte_count_nxt;
  logic [31:0]      start_time_r;
  logic [7:0]       body_r [STORE_N];
  logic [31:0]      elapsed;
  logic             timed_out;
  logic             store_byte;
  logic             frame_end;
  logic [7:0]       calc;

  // Age of the current frame, wrapping modulo 2^32
  assign elapsed   = item.now_ms - start_time_r;
  assign timed_out = elapsed > {16'd0, cfg.frame_timeout_ms};

  // Decide what this byte does
  always_comb begin
    collecting_nxt = collecting_r;
    byte_count_nxt = byte_count_r;
    store_byte     = 1'b0;
    frame_end      = 1'b0;
    if (!collecting_r) begin
      if (item.rx_byte == cfg.start_marker) begin
        collecting_nxt = 1'b1;
        byte_count_nxt = 3'd0;
      end
    end else if (timed_out || byte_count_r > cfr_pkg::LAST_IDX) begin
      collecting_nxt = 1'b0;
      byte_count_nxt = 3'd0;
    end else if (byte_count_r == cfr_pkg::LAST_IDX) begin
      frame_end      = 1'b1;
      collecting_nxt = 1'b0;
      byte_count_nxt = 3'd0;
    end else begin
      store_byte     = 1'b1;
      byte_count_nxt = byte_count_r + 3'd1;
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      byte_count_r <= 3'd0;
      start_time_r <= 32'd0;
    end else if (step) begin
      collecting_r <= collecting_nxt;
      byte_count_r <= byte_count_nxt;
      if (!collecting_r && item.rx_byte == cfg.start_marker) begin
        start_time_r <= item.now_ms;
      end
    end
  end

  // Collect the four body bytes before the checksum
  always_ff @(posedge clk) begin
    if (step && store_byte) begin
      body_r[byte_count_r[1:0]] <= item.rx_byte;
    end
  end

  // Check the completed frame; the checksum is the byte now arriving
  assign calc      = body_r[0] ^ body_r[1] ^ body_r[2] ^ body_r[3];
  assign res_valid = step && frame_end && item.rx_byte == calc
                     && body_r[0] == cfg.own_node_id;

  assign res.node_id       = body_r[0];
  assign res.device_addr   = body_r[1];
  assign res.command       = body_r[2];
  assign res.parameter_res = body_r[3];
  assign res.checksum      = item.rx_byte;

endmodule

[design/cfr_out_stage.sv]
// Result register of the command frame receiver: holds one decoded frame
// until the consumer takes it. Depends on cfr_pkg for cfr_frame_t.
module cfr_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  cfr_pkg::cfr_frame_t res,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_node_id,
  output logic [7:0]          out_device_addr,
  output logic [7:0]          out_command,
  output logic [7:0]          out_parameter_res,
  output logic [7:0]          out_checksum
);

  logic                valid_r;
  logic                valid_nxt;
  cfr_pkg::cfr_frame_t frame_r;
  logic                load;

  // Free once empty or while the held transaction is being taken
  assign ready = !valid_r || !out_stall;
  assign load  = ready && res_valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_node_id       = frame_r.node_id;
  assign out_device_addr   = frame_r.device_addr;
  assign out_command       = frame_r.command;
  assign out_parameter_res = frame_r.parameter_res;
  assign out_checksum      = frame_r.checksum;

endmodule

[design/command_frame_receiver.sv]
// Command frame receiver: top level joining the register file, input
// register, frame logic and result register. Depends on cfr_pkg and submodules.
//
// Takes one received byte per transaction, each with a millisecond timestamp,
// and delivers one result per well-formed frame for its own board id: start
// marker, board id, address, command, parameter and an XOR checksum of the
// four. One byte is accepted every clock cycle while the result side keeps
// up; each checksum byte is held in the input register and passes a single
// pass of frame logic, and its result is offered from the result register.
// A frame whose bytes arrive later than frame_timeout_ms after the marker is
// abandoned, and the late byte is discarded even if it equals the marker.
// Write the configuration registers (0 start marker, 1 own board id,
// 2 timeout) only when no transaction is in flight; there is no start-up
// clearing pass.
module command_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_node_id,
  output logic [7:0]  out_device_addr,
  output logic [7:0]  out_command,
  output logic [7:0]  out_parameter_res,
  output logic [7:0]  out_checksum
);

  cfr_pkg::cfr_cfg_t   cfg;
  cfr_pkg::cfr_item_t  item;
  cfr_pkg::cfr_frame_t res;
  logic                item_valid;
  logic                ready;
  logic                step;
  logic                res_valid;

  // Process the held byte whenever the result register can take its outcome
  assign step = item_valid && ready;

  cfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .in_now_ms  (in_now_ms),
    .advance    (ready),
    .item_valid (item_valid),
    .item       (item)
  );

  cfr_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  cfr_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res               (res),
    .ready             (ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_node_id       (out_node_id),
    .out_device_addr   (out_device_addr),
    .out_command       (out_command),
    .out_parameter_res (out_parameter_res),
    .out_checksum      (out_checksum)
  );

endmodule

[design/cfr_checker.sv]
// Port-level checks for the command frame receiver, bound to the top level.
// Depends only on the top level's port names.
module cfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_node_id,
  input logic [7:0]  out_device_addr,
  input logic [7:0]  out_command,
  input logic [7:0]  out_parameter_res,
  input logic [7:0]  out_checksum
);

  // No result is pending straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Every delivered frame carries a consistent checksum
  a_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_checksum == (out_node_id ^ out_device_addr
                                   ^ out_command ^ out_parameter_res))
    else $error("result checksum does not match its fields");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result withdrawn");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_node_id) && $stable(out_device_addr)
      && $stable(out_command) && $stable(out_parameter_res) && $stable(out_checksum))
    else $error("stalled result changed");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (.*);

[verif/command_frame_receiver_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for command_frame_receiver: random framed byte streams,
// register settings and handshake pressure, checked against a frame decoder model.
// Depends on cfr_pkg and the command_frame_receiver design files.
module command_frame_receiver_tb;

  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 240;
  localparam logic [1:0]  CFG_UNUSED_IDX = 2'd3;

  typedef enum int {SEQ_GOOD, SEQ_BAD_SUM, SEQ_FOREIGN, SEQ_LATE, SEQ_TRUNCATED,
                    SEQ_NOISE} seq_kind_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // Decodes accepted bytes into expected frames and checks delivered ones
  class frame_scoreboard;
    logic [7:0]          start_marker;
    logic [7:0]          own_id;
    logic [15:0]         timeout_ms;
    bit                  collecting;
    int unsigned         body_cnt;
    logic [31:0]         start_ms;
    logic [7:0]          body [cfr_pkg::BODY_LEN];
    cfr_pkg::cfr_frame_t expected_frames [$];
    int unsigned         mismatches;
    int unsigned         frames_checked;
    int unsigned         late_drops;

    function new();
      start_marker   = cfr_pkg::START_MARKER_RST;
      own_id         = cfr_pkg::OWN_BOARD_ID_RST;
      timeout_ms     = cfr_pkg::FRAME_TIMEOUT_RST;
      collecting     = 1'b0;
      body_cnt       = 0;
      start_ms       = '0;
      mismatches     = 0;
      frames_checked = 0;
      late_drops     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        cfr_pkg::CFG_START_MARKER:  start_marker = data[7:0];
        cfr_pkg::CFG_OWN_BOARD_ID:  own_id = data[7:0];
        cfr_pkg::CFG_FRAME_TIMEOUT: timeout_ms = data;
        default: ;
      endcase
    endfunction

    // Advance the frame state by one accepted transaction
    function void decode_byte(logic [7:0] rx, logic [31:0] now);
      logic [31:0]         age;
      cfr_pkg::cfr_frame_t f;
      if (!collecting) begin
        if (rx == start_marker) begin
          collecting = 1'b1;
          body_cnt   = 0;
          start_ms   = now;
        end
        return;
      end
      // Drop a late byte and abandon the frame, marker or not
      age = now - start_ms;
      if (age > {16'd0, timeout_ms}) begin
        late_drops++;
        collecting = 1'b0;
        body_cnt   = 0;
        return;
      end
      if (body_cnt >= cfr_pkg::BODY_LEN) begin
        collecting = 1'b0;
        body_cnt   = 0;
        return;
      end
      body[body_cnt] = rx;
      body_cnt++;
      if (body_cnt < cfr_pkg::BODY_LEN) return;
      collecting = 1'b0;
      body_cnt   = 0;
      if (body[4] == (body[0] ^ body[1] ^ body[2] ^ body[3]) && body[0] == own_id) begin
        f = {body[0], body[1], body[2], body[3], body[4]};
        expected_frames.push_back(f);
      end
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_frame(cfr_pkg::cfr_frame_t got);
      cfr_pkg::cfr_frame_t exp_f;
      if (expected_frames.size() == 0) begin
        $error("unexpected frame: node_id 0x%02h device_addr 0x%02h command 0x%02h",
               got.node_id, got.device_addr, got.command);
        mismatches++;
        return;
      end
      exp_f = expected_frames.pop_front();
      compare_field("node_id", exp_f.node_id, got.node_id);
      compare_field("device_addr", exp_f.device_addr, got.device_addr);
      compare_field("command", exp_f.command, got.command);
      compare_field("parameter_res", exp_f.parameter_res, got.parameter_res);
      compare_field("checksum", exp_f.checksum, got.checksum);
      frames_checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic [31:0] in_now_ms;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_node_id;
  logic [7:0]  out_device_addr;
  logic [7:0]  out_command;
  logic [7:0]  out_parameter_res;
  logic [7:0]  out_checksum;

  frame_scoreboard frame_sb;
  int unsigned     bytes_sent;
  int unsigned     burst_left;
  int unsigned     input_backpressure;
  int unsigned     quiet_cycles;
  bit              hold_req;

  command_frame_receiver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_node_id       (out_node_id),
    .out_device_addr   (out_device_addr),
    .out_command       (out_command),
    .out_parameter_res (out_parameter_res),
    .out_checksum      (out_checksum)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Note accepted input and check delivered frames at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) frame_sb.decode_byte(in_rx_byte, in_now_ms);
    if (rst_n && in_valid && in_stall) input_backpressure++;
    if (rst_n && out_valid && !out_stall)
      frame_sb.check_frame({out_node_id, out_device_addr, out_command,
                            out_parameter_res, out_checksum});
  end

  // Abort if nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("command_frame_receiver test failed");
      $finish;
    end
  end

  // Result side: stall pattern that changes mode now and then, plus one long hold-off
  always @(negedge clk) begin : result_stall
    static stall_mode_t mode = STALL_NONE;
    static int unsigned mode_left = 0;
    static int unsigned hold_left = 0;
    static bit hold_taken = 1'b0;
    static int unsigned tick = 0;
    tick++;
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      mode      = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 96);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      case (mode)
        STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall = ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall = (tick % 4 == 0);
        default:        out_stall = 1'b0;
      endcase
    end
  end

  // Offer one byte, with burst gaps, and hold it until accepted
  task automatic send_item(input logic [7:0] rx, input logic [31:0] now);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_rx_byte = rx;
    in_now_ms  = now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Wait until every frame is out and the pipeline has emptied
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (frame_sb.expected_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    frame_sb.write_reg(idx, data);
  endtask

  // One byte sequence of the given kind, built for the current register values
  task automatic send_sequence(input seq_kind_t kind);
    logic [4:0][7:0] body;
    logic [31:0]     t0;
    logic [31:0]     ofs;
    logic [31:0]     tmo;
    logic [7:0]      marker;
    int              n_body;
    int              late_at;
    int              k;
    marker = frame_sb.start_marker;
    tmo    = {16'd0, frame_sb.timeout_ms};
    if (kind == SEQ_NOISE) begin
      n_body = $urandom_range(1, 6);
      for (k = 0; k < n_body; k++)
        send_item(($urandom_range(0, 4) == 0) ? marker : 8'($urandom()), $urandom());
      return;
    end
    body[0] = (kind == SEQ_FOREIGN) ? (frame_sb.own_id ^ 8'($urandom_range(1, 255)))
                                    : frame_sb.own_id;
    for (k = 1; k < 4; k++)
      body[k] = ($urandom_range(0, 9) == 0) ? marker : 8'($urandom());
    body[4] = body[0] ^ body[1] ^ body[2] ^ body[3];
    if (kind == SEQ_BAD_SUM) body[4] = body[4] ^ 8'($urandom_range(1, 255));
    n_body  = (kind == SEQ_TRUNCATED) ? $urandom_range(1, 4) : 5;
    late_at = (kind == SEQ_LATE) ? $urandom_range(0, 4) : 5;
    t0      = $urandom();
    ofs     = '0;
    send_item(marker, t0);
    for (k = 0; k < n_body; k++) begin
      if (k == late_at) begin
        // Late byte, sometimes a marker, sometimes stamped before the start
        send_item(($urandom_range(0, 2) == 0) ? marker : body[k],
                  ($urandom_range(0, 4) == 0) ? t0 - $urandom_range(1, 1000)
                                              : t0 + tmo + 1 + $urandom_range(0, 50));
        break;
      end
      if ($urandom_range(0, 3) == 0) ofs = $urandom_range(ofs, tmo);
      else ofs = (ofs + 2 > tmo) ? tmo : ofs + $urandom_range(0, 2);
      if (k == 4 && $urandom_range(0, 7) == 0) ofs = tmo;
      send_item(body[k], t0 + ofs);
    end
  endtask

  function automatic seq_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return SEQ_GOOD;
    if (r < 68) return SEQ_BAD_SUM;
    if (r < 76) return SEQ_FOREIGN;
    if (r < 84) return SEQ_LATE;
    if (r < 90) return SEQ_TRUNCATED;
    return SEQ_NOISE;
  endfunction

  task automatic run_random(input int unsigned n_items);
    int unsigned target;
    target = bytes_sent + n_items;
    while (bytes_sent < target) send_sequence(pick_kind());
  endtask

  initial begin
    int unsigned i;
    frame_sb           = new();
    bytes_sent         = 0;
    burst_left         = 0;
    input_backpressure = 0;
    quiet_cycles       = 0;
    hold_req           = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = cfr_pkg::CFG_START_MARKER;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_rx_byte         = '0;
    in_now_ms          = '0;
    out_stall          = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Good frame across the time wrap, last byte exactly at the timeout
    send_item(cfr_pkg::START_MARKER_RST, 32'hFFFF_FFFF);
    send_item(cfr_pkg::OWN_BOARD_ID_RST, 32'h0000_0000);
    send_item(8'hFF, 32'h0000_0001);
    send_item(8'h00, 32'h0000_0031);
    send_item(8'h80, 32'h0000_0062);
    send_item(8'h7E, 32'h0000_0063);
    // Markers inside a frame, foreign board id
    send_item(cfr_pkg::START_MARKER_RST, 32'h0000_1000);
    send_item(8'h02, 32'h0000_1000);
    send_item(cfr_pkg::START_MARKER_RST, 32'h0000_1000);
    send_item(cfr_pkg::START_MARKER_RST, 32'h0000_1000);
    send_item(cfr_pkg::START_MARKER_RST, 32'h0000_1000);
    send_item(8'hA8, 32'h0000_1000);
    // Bad checksum
    send_item(cfr_pkg::START_MARKER_RST, 32'h8000_0000);
    send_item(cfr_pkg::OWN_BOARD_ID_RST, 32'h8000_0001);
    send_item(8'h10, 32'h8000_0002);
    send_item(8'h20, 32'h8000_0003);
    send_item(8'h30, 32'h8000_0004);
    send_item(8'h00, 32'h8000_0005);
    // Late marker is dropped without reopening; the next byte meets an idle block
    send_item(cfr_pkg::START_MARKER_RST, 32'd5000);
    send_item(cfr_pkg::START_MARKER_RST, 32'd5101);
    send_item(cfr_pkg::OWN_BOARD_ID_RST, 32'd5101);
    // Byte stamped before its marker counts as ancient
    send_item(cfr_pkg::START_MARKER_RST, 32'd200);
    send_item(8'h55, 32'd199);

    // Long result hold-off while good frames keep coming
    hold_req = 1'b1;
    for (i = 0; i < 25; i++) send_sequence(SEQ_GOOD);
    run_random(PHASE_ITEMS);
    wait_idle();

    // Extreme settings: marker zero, id all ones, zero timeout
    write_cfg(cfr_pkg::CFG_START_MARKER, {8'($urandom()), 8'h00});
    write_cfg(cfr_pkg::CFG_OWN_BOARD_ID, {8'($urandom()), 8'hFF});
    write_cfg(cfr_pkg::CFG_FRAME_TIMEOUT, 16'h0000);
    run_random(PHASE_ITEMS);
    wait_idle();

    // Opposite extremes, and a write to the unused index
    write_cfg(cfr_pkg::CFG_START_MARKER, {8'($urandom()), 8'hFF});
    write_cfg(cfr_pkg::CFG_OWN_BOARD_ID, {8'($urandom()), 8'h00});
    write_cfg(cfr_pkg::CFG_FRAME_TIMEOUT, 16'hFFFF);
    write_cfg(CFG_UNUSED_IDX, 16'($urandom()));
    run_random(PHASE_ITEMS);
    wait_idle();

    // Random settings with a short timeout
    write_cfg(cfr_pkg::CFG_START_MARKER, 16'($urandom()));
    write_cfg(cfr_pkg::CFG_OWN_BOARD_ID, 16'($urandom()));
    write_cfg(cfr_pkg::CFG_FRAME_TIMEOUT, 16'($urandom_range(1, 300)));
    run_random(PHASE_ITEMS);
    wait_idle();

    $display("Covered %0d bytes, %0d frames delivered, %0d late bytes dropped",
             bytes_sent, frame_sb.frames_checked, frame_sb.late_drops);
    $display("Four register settings incl. zero and full timeout, %0d input stall cycles",
             input_backpressure);
    if (frame_sb.mismatches == 0) begin
      $display("command_frame_receiver test passed");
    end else begin
      $display("command_frame_receiver test failed");
    end
    $finish;
  end

endmodule

[files.f]
design/cfr_pkg.sv
design/cfr_cfg_regs.sv
design/cfr_in_stage.sv
design/cfr_frame_core.sv
design/cfr_out_stage.sv
design/command_frame_receiver.sv
design/cfr_checker.sv
verif/command_frame_receiver_tb.sv
